// ===== rtl/xfc_pkg.sv =====
// ----------------------------------------------------------------------------
// xfc_pkg: shared types and constants for the XOR frame checker
// Frame layout positions, result record and stream widths.
// ----------------------------------------------------------------------------
package xfc_pkg;

    // byte positions inside a frame
    localparam int POS_LEN_HI  = 2;   // length word, high byte
    localparam int POS_LEN_LO  = 3;   // length word, low byte
    localparam int POS_CMD     = 6;   // sub-command byte
    localparam int TAIL_DEPTH  = 4;   // check word plus two trailer bytes
    localparam int MIN_FRAME   = 4;   // shortest frame that has a check word

    localparam int CNT_OUT_W   = 11;  // width of the reported byte count
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;  // 21 result bits padded to whole bytes

    // one result, packed with frame_ok in the lowest bit
    typedef struct packed {
        logic [CNT_OUT_W-1:0] byte_count;
        logic [7:0]           sub_command;
        logic                 length_ok;
        logic                 frame_ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== rtl/xfc_frame_state.sv =====
// ----------------------------------------------------------------------------
// xfc_frame_state: per-frame accumulator
// Tracks byte count, length word, sub-command, tail delay line and XOR,
// and forms the frame result from the values after the current byte.
// ----------------------------------------------------------------------------
module xfc_frame_state #(
    parameter int MAX_FRAME = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,     // byte transfer this cycle
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output xfc_pkg::t_result o_result    // valid in the cycle of i_take
);
    import xfc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] r_count,  n_count;
    logic [15:0]   r_length, n_length;
    logic [7:0]    r_xor,    n_xor;
    logic [7:0]    r_cmd,    n_cmd;
    logic [7:0]    r_tail [TAIL_DEPTH];
    logic [7:0]    n_tail [TAIL_DEPTH];
    logic          too_long;
    logic          len_ok;
    logic          sum_ok;

    always_comb begin
        too_long = (r_count >= CW'(MAX_FRAME));
        n_count  = too_long ? r_count : r_count + CW'(1);

        n_length = r_length;
        n_cmd    = r_cmd;
        if (r_count == CW'(POS_LEN_HI)) begin
            n_length[15:8] = i_byte;
        end else if (r_count == CW'(POS_LEN_LO)) begin
            n_length[7:0] = i_byte;
        end else if (r_count == CW'(POS_CMD)) begin
            n_cmd = i_byte;
        end

        // oldest tail byte drops into the XOR once the line is full
        n_xor = (r_count >= CW'(TAIL_DEPTH)) ? (r_xor ^ r_tail[0]) : r_xor;
        for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
            n_tail[i] = r_tail[i+1];
        end
        n_tail[TAIL_DEPTH-1] = i_byte;

        len_ok = !too_long && (n_count >= CW'(MIN_FRAME)) && (n_length == 16'(n_count));
        // check word is {n_tail[0], n_tail[1]}; XOR is zero-extended
        sum_ok = (n_tail[0] == 8'h00) && (n_tail[1] == n_xor);

        o_result.frame_ok    = len_ok && sum_ok;
        o_result.length_ok   = len_ok;
        o_result.sub_command = n_cmd;
        o_result.byte_count  = CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_count  <= '0;
            r_length <= '0;
            r_xor    <= '0;
            r_cmd    <= '0;
            for (int i = 0; i < TAIL_DEPTH; i++) begin
                r_tail[i] <= '0;
            end
        end else if (i_take) begin
            r_count  <= n_count;
            r_length <= n_length;
            r_xor    <= n_xor;
            r_cmd    <= n_cmd;
            for (int i = 0; i < TAIL_DEPTH; i++) begin
                r_tail[i] <= n_tail[i];
            end
        end
    end

endmodule

// ===== rtl/xor_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// xor_frame_checker_unit: frame length and XOR checksum checker
// Takes one frame byte per transfer and reports one result per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while s_axis_tready is high; the per-frame state updates in a single pass.
// The result is registered and appears on m_axis in the cycle after the last byte transfer.
// The result register decouples the sides: bytes keep flowing while a result
// waits; only a last byte that meets a full result register with
// m_axis_tready low is stalled.
// Reset (i_rst_n low, synchronous) clears the frame state and the result valid.
module xor_frame_checker_unit #(
    parameter int MAX_FRAME = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tlast,   // last_byte
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [xfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
        // [0] frame_ok, [1] length_ok, [9:2] sub_command, [20:10] byte_count,
        // [23:21] zero
);
    import xfc_pkg::*;

    logic    take;
    t_result result;
    logic    r_m_valid;
    t_result r_m_data;

    // non-final bytes always pass; a final byte needs room for its result
    assign s_axis_tready = !r_m_valid || m_axis_tready || !s_axis_tlast;
    assign take          = s_axis_tvalid && s_axis_tready;

    xfc_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (result)
    );

    // result register: loaded on the last byte of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (take && s_axis_tlast) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && s_axis_tlast) begin
            r_m_data <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_m_data};

endmodule

// ===== rtl/xfc_checker.sv =====
// ----------------------------------------------------------------------------
// xfc_checker: port-level assertions for the XOR frame checker
// Watches both streams of the top level; attached by bind.
// ----------------------------------------------------------------------------
module xfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [xfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import xfc_pkg::*;

    // frame_ok never without length_ok
    a_ok_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("frame_ok set without length_ok");

    // last byte transfer yields a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("no result after last byte");

    // no result appears from a non-last byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(s_axis_tvalid && s_axis_tready && s_axis_tlast)
         && (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid)
        else $error("result without last byte");

    // empty result register never stalls input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind xor_frame_checker_unit xfc_checker u_xfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
